// ===== sv/i2p_pkg.sv =====
`timescale 1ns / 1ps

package i2p_pkg;

    typedef logic [2:0]  kind_t;
    typedef logic [31:0] value_t;
    typedef logic [1:0]  status_t;

    localparam kind_t KIND_NUM   = 3'd0;
    localparam kind_t KIND_PLUS  = 3'd1;
    localparam kind_t KIND_MINUS = 3'd2;
    localparam kind_t KIND_TIMES = 3'd3;
    localparam kind_t KIND_DIV   = 3'd4;
    localparam kind_t KIND_OPEN  = 3'd5;
    localparam kind_t KIND_CLOSE = 3'd6;
    localparam kind_t KIND_RSVD  = 3'd7;
    localparam kind_t KIND_NONE  = 3'd5;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_CLOSE = 2'd2;
    localparam status_t STAT_OPEN  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOKEN,
        ST_READ,
        ST_EXAM,
        ST_LASTCHK,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        LOOP_CLOSE,
        LOOP_OPER,
        LOOP_FLUSH
    } loop_t;

    function automatic logic is_high(input kind_t k);
        return (k == KIND_TIMES) || (k == KIND_DIV);
    endfunction

    function automatic logic is_low(input kind_t k);
        return (k == KIND_PLUS) || (k == KIND_MINUS);
    endfunction

endpackage

// ===== sv/i2p_ifs.sv =====
`timescale 1ns / 1ps

interface i2p_token_if;
    logic             valid;
    logic             ready;
    i2p_pkg::kind_t   token_kind;
    i2p_pkg::value_t  token_value;
    logic             expr_last;

    modport source (output valid, token_kind, token_value, expr_last, input ready);
    modport sink   (input valid, token_kind, token_value, expr_last, output ready);
endinterface

interface i2p_result_if;
    logic              valid;
    logic              ready;
    i2p_pkg::kind_t    out_kind;
    i2p_pkg::value_t   out_value;
    i2p_pkg::status_t  out_status;
    logic              run_last;
    logic              expr_done;

    modport source (output valid, out_kind, out_value, out_status, run_last, expr_done,
                    input ready);
    modport sink   (input valid, out_kind, out_value, out_status, run_last, expr_done,
                    output ready);
endinterface

// ===== sv/infix_to_postfix_converter_top.sv =====
`timescale 1ns / 1ps

// Channel  Role    Request contents
// tok      sink    token_kind, token_value, expr_last
// res      source  out_kind, out_value, out_status, run_last, expr_done
//
// A number, open paren or ignored token passes from acceptance through ST_TOKEN,
// ST_LASTCHK and ST_FINISH; a close paren or operator goes from ST_TOKEN to ST_READ,
// then through ST_EXAM and back to ST_READ for each stack entry it examines. A final
// token flushes the stack through ST_READ and ST_EXAM per entry (registered read).
// Reset empties the stack at once. A stalled result side holds the sequencer when the
// hold stage and output register are both full, or when a final token with no other
// result meets a full output register.

module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    i2p_token_if.sink     tok,
    i2p_result_if.source  res
);
    import i2p_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    state_t        state_reg, state_next;
    loop_t         mode_reg, mode_next;
    kind_t         kind_reg, kind_next;
    value_t        value_reg, value_next;
    logic          last_reg, last_next;
    logic          open_left_reg, open_left_next;
    logic [CW-1:0] count_reg, count_next;

    logic          pend_valid_reg, pend_valid_next;
    kind_t         pend_kind_reg, pend_kind_next;
    value_t        pend_value_reg, pend_value_next;
    status_t       pend_status_reg, pend_status_next;

    logic          out_valid_reg, out_valid_next;
    kind_t         out_kind_reg, out_kind_next;
    value_t        out_value_reg, out_value_next;
    status_t       out_status_reg, out_status_next;
    logic          out_run_last_reg, out_run_last_next;
    logic          out_expr_done_reg, out_expr_done_next;

    logic          out_free;
    logic          emit_ok;
    logic          want_emit;
    kind_t         emit_kind;
    value_t        emit_value;
    status_t       emit_status;
    logic          do_push;
    kind_t         push_kind;
    logic          do_pop;
    state_t        state_prop;
    loop_t         mode_prop;
    logic          set_open;
    logic          clr_open;
    logic          stall;
    logic          ram_we;
    logic [AW-1:0] raddr;
    kind_t         top_kind;
    logic          full;

    assign raddr = AW'(count_reg - 1'b1);
    assign full  = (count_reg == FULL_COUNT);

    i2p_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (push_kind),
        .raddr (raddr),
        .rdata (top_kind)
    );

    assign tok.ready      = (state_reg == ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.out_kind   = out_kind_reg;
    assign res.out_value  = out_value_reg;
    assign res.out_status = out_status_reg;
    assign res.run_last   = out_run_last_reg;
    assign res.expr_done  = out_expr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg          <= mode_next;
        kind_reg          <= kind_next;
        value_reg         <= value_next;
        last_reg          <= last_next;
        open_left_reg     <= open_left_next;
        pend_kind_reg     <= pend_kind_next;
        pend_value_reg    <= pend_value_next;
        pend_status_reg   <= pend_status_next;
        out_kind_reg      <= out_kind_next;
        out_value_reg     <= out_value_next;
        out_status_reg    <= out_status_next;
        out_run_last_reg  <= out_run_last_next;
        out_expr_done_reg <= out_expr_done_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        mode_next          = mode_reg;
        kind_next          = kind_reg;
        value_next         = value_reg;
        last_next          = last_reg;
        open_left_next     = open_left_reg;
        count_next         = count_reg;
        pend_valid_next    = pend_valid_reg;
        pend_kind_next     = pend_kind_reg;
        pend_value_next    = pend_value_reg;
        pend_status_next   = pend_status_reg;
        out_valid_next     = out_valid_reg;
        out_kind_next      = out_kind_reg;
        out_value_next     = out_value_reg;
        out_status_next    = out_status_reg;
        out_run_last_next  = out_run_last_reg;
        out_expr_done_next = out_expr_done_reg;

        want_emit   = 1'b0;
        emit_kind   = KIND_NONE;
        emit_value  = '0;
        emit_status = STAT_OK;
        do_push     = 1'b0;
        push_kind   = kind_reg;
        do_pop      = 1'b0;
        state_prop  = state_reg;
        mode_prop   = mode_reg;
        set_open    = 1'b0;
        clr_open    = 1'b0;
        ram_we      = 1'b0;

        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        out_free = !out_valid_reg || res.ready;
        emit_ok  = !pend_valid_reg || out_free;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tok.valid)
                begin
                    kind_next  = tok.token_kind;
                    value_next = tok.token_value;
                    last_next  = tok.expr_last;
                    state_prop = ST_TOKEN;
                end
            end
            ST_TOKEN:
            begin
                unique case (kind_reg)
                    KIND_NUM:
                    begin
                        want_emit   = 1'b1;
                        emit_kind   = KIND_NUM;
                        emit_value  = value_reg;
                        state_prop  = ST_LASTCHK;
                    end
                    KIND_OPEN:
                    begin
                        if (full)
                        begin
                            want_emit   = 1'b1;
                            emit_status = STAT_FULL;
                        end
                        else
                        begin
                            do_push = 1'b1;
                        end
                        state_prop = ST_LASTCHK;
                    end
                    KIND_CLOSE:
                    begin
                        mode_prop  = LOOP_CLOSE;
                        state_prop = ST_READ;
                    end
                    KIND_PLUS, KIND_MINUS, KIND_TIMES, KIND_DIV:
                    begin
                        mode_prop  = LOOP_OPER;
                        state_prop = ST_READ;
                    end
                    default:
                    begin
                        state_prop = ST_LASTCHK;
                    end
                endcase
            end
            ST_READ:
            begin
                if (count_reg == '0)
                begin
                    unique case (mode_reg)
                        LOOP_CLOSE:
                        begin
                            want_emit   = 1'b1;
                            emit_status = STAT_CLOSE;
                            state_prop  = ST_LASTCHK;
                        end
                        LOOP_OPER:
                        begin
                            do_push    = 1'b1;
                            state_prop = ST_LASTCHK;
                        end
                        LOOP_FLUSH:
                        begin
                            if (open_left_reg)
                            begin
                                want_emit   = 1'b1;
                                emit_status = STAT_OPEN;
                            end
                            state_prop = ST_FINISH;
                        end
                        default:
                        begin
                            state_prop = ST_FINISH;
                        end
                    endcase
                end
                else
                begin
                    state_prop = ST_EXAM;
                end
            end
            ST_EXAM:
            begin
                unique case (mode_reg)
                    LOOP_CLOSE:
                    begin
                        do_pop = 1'b1;
                        if (top_kind == KIND_OPEN)
                        begin
                            state_prop = ST_LASTCHK;
                        end
                        else
                        begin
                            want_emit  = 1'b1;
                            emit_kind  = top_kind;
                            state_prop = ST_READ;
                        end
                    end
                    LOOP_OPER:
                    begin
                        if ((top_kind == KIND_OPEN) ||
                            (is_high(kind_reg) && is_low(top_kind)))
                        begin
                            if (full)
                            begin
                                want_emit   = 1'b1;
                                emit_status = STAT_FULL;
                            end
                            else
                            begin
                                do_push = 1'b1;
                            end
                            state_prop = ST_LASTCHK;
                        end
                        else
                        begin
                            want_emit  = 1'b1;
                            emit_kind  = top_kind;
                            do_pop     = 1'b1;
                            state_prop = ST_READ;
                        end
                    end
                    LOOP_FLUSH:
                    begin
                        do_pop = 1'b1;
                        if (top_kind == KIND_OPEN)
                        begin
                            set_open = 1'b1;
                        end
                        else
                        begin
                            want_emit = 1'b1;
                            emit_kind = top_kind;
                        end
                        state_prop = ST_READ;
                    end
                    default:
                    begin
                        state_prop = ST_READ;
                    end
                endcase
            end
            ST_LASTCHK:
            begin
                if (last_reg)
                begin
                    mode_prop  = LOOP_FLUSH;
                    clr_open   = 1'b1;
                    state_prop = ST_READ;
                end
                else
                begin
                    state_prop = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (pend_valid_reg || last_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next     = 1'b1;
                        out_kind_next      = pend_valid_reg ? pend_kind_reg : KIND_NONE;
                        out_value_next     = pend_valid_reg ? pend_value_reg : '0;
                        out_status_next    = pend_valid_reg ? pend_status_reg : STAT_OK;
                        out_run_last_next  = 1'b1;
                        out_expr_done_next = last_reg;
                        pend_valid_next    = 1'b0;
                        state_prop         = ST_IDLE;
                    end
                end
                else
                begin
                    state_prop = ST_IDLE;
                end
            end
            default:
            begin
                state_prop = ST_IDLE;
            end
        endcase

        stall = want_emit && !emit_ok;

        if (!stall)
        begin
            state_next = state_prop;
            mode_next  = mode_prop;
            if (clr_open)
            begin
                open_left_next = 1'b0;
            end
            if (set_open)
            begin
                open_left_next = 1'b1;
            end
            if (want_emit)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next     = 1'b1;
                    out_kind_next      = pend_kind_reg;
                    out_value_next     = pend_value_reg;
                    out_status_next    = pend_status_reg;
                    out_run_last_next  = 1'b0;
                    out_expr_done_next = 1'b0;
                end
                pend_valid_next  = 1'b1;
                pend_kind_next   = emit_kind;
                pend_value_next  = emit_value;
                pend_status_next = emit_status;
            end
            if (do_push)
            begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
            if (do_pop)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/i2p_stack_ram.sv =====
`timescale 1ns / 1ps

module i2p_stack_ram #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  i2p_pkg::kind_t       wdata,
    input  logic [AW-1:0]        raddr,
    output i2p_pkg::kind_t       rdata
);
    import i2p_pkg::*;

    kind_t mem [DEPTH];
    kind_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
